// ===== rtl/mm64_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm64_pkg
// Shared constants, command and status types of the 64-bit murmur hash core.
// ----------------------------------------------------------------------------
package mm64_pkg;

    localparam int DATA_W  = 64;
    localparam int HALF_W  = 32;
    localparam int LEN_W   = 31;
    localparam int CNT_W   = 4;
    localparam int NBYTES  = 8;

    // mixing multiplier and its halves
    localparam logic [DATA_W-1:0] MIX_MULT   = 64'hc6a4a7935bd1e995;
    localparam logic [HALF_W-1:0] MIX_MULT_L = MIX_MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0] MIX_MULT_H = MIX_MULT[DATA_W-1:HALF_W];
    localparam int                MIX_SHIFT  = 47;

    // partial product steps of the multiplier
    typedef enum logic [1:0] {
        MP_IDLE,
        MP_LO,
        MP_HL,
        MP_LH
    } t_mul_phase;

    // multiplier operand source
    typedef enum logic [2:0] {
        X_HOLD,
        X_LEN,
        X_WORD,
        X_KMIX,
        X_HK,
        X_TAIL,
        X_AVAL
    } t_x_sel;

    // accumulator source
    typedef enum logic [1:0] {
        H_HOLD,
        H_SEED,
        H_PROD
    } t_h_sel;

    typedef struct packed {
        logic       load_in;
        t_x_sel     x_sel;
        t_h_sel     h_sel;
        t_mul_phase mul;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic first;
        logic last;
        logic cnt_full;
        logic cnt_zero;
        logic out_busy;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== rtl/mm64_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm64_mul
// Low 64 bits of operand times the mixing constant, built from three
// 32x32 partial products on one shared multiplier.
// ----------------------------------------------------------------------------
module mm64_mul (
    input  wire logic                          i_clk,
    input  wire mm64_pkg::t_mul_phase          i_phase,
    input  wire logic [mm64_pkg::DATA_W-1:0]   i_operand,
    output logic      [mm64_pkg::DATA_W-1:0]   o_product
);

    logic [mm64_pkg::HALF_W-1:0] w_a;
    logic [mm64_pkg::HALF_W-1:0] w_b;
    logic [mm64_pkg::DATA_W-1:0] w_full;
    logic [mm64_pkg::HALF_W-1:0] w_mid;
    logic [mm64_pkg::DATA_W-1:0] r_p0;
    logic [mm64_pkg::HALF_W-1:0] r_p1;
    logic [mm64_pkg::HALF_W-1:0] r_p2;

    // operand selection per step
    always_comb begin
        w_a = i_operand[mm64_pkg::HALF_W-1:0];
        w_b = mm64_pkg::MIX_MULT_L;
        unique case (i_phase)
            mm64_pkg::MP_HL: begin
                w_a = i_operand[mm64_pkg::DATA_W-1:mm64_pkg::HALF_W];
            end
            mm64_pkg::MP_LH: begin
                w_b = mm64_pkg::MIX_MULT_H;
            end
            default: begin
            end
        endcase
    end

    assign w_full = {{mm64_pkg::HALF_W{1'b0}}, w_a} * {{mm64_pkg::HALF_W{1'b0}}, w_b};

    // partial product registers
    always_ff @(posedge i_clk) begin
        unique case (i_phase)
            mm64_pkg::MP_LO: r_p0 <= w_full;
            mm64_pkg::MP_HL: r_p1 <= w_full[mm64_pkg::HALF_W-1:0];
            mm64_pkg::MP_LH: r_p2 <= w_full[mm64_pkg::HALF_W-1:0];
            default: begin
            end
        endcase
    end

    // cross terms only reach the upper half
    assign w_mid     = r_p1 + r_p2;
    assign o_product = r_p0 + {w_mid, {mm64_pkg::HALF_W{1'b0}}};

endmodule
`default_nettype wire

// ===== rtl/mm64_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm64_dpath
// Hash datapath: captured transaction, seed, accumulator, multiplier
// operand and the output register.
// ----------------------------------------------------------------------------
module mm64_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mm64_pkg::DATA_W-1:0]   i_cfg_wdata,
    input  wire logic [mm64_pkg::DATA_W-1:0]   i_data_word,
    input  wire logic [mm64_pkg::CNT_W-1:0]    i_valid_bytes,
    input  wire logic                          i_first_item,
    input  wire logic                          i_last_item,
    input  wire logic [mm64_pkg::LEN_W-1:0]    i_total_length,
    input  wire logic                          i_out_stall,
    input  wire mm64_pkg::t_dp_cmd             i_cmd,
    output mm64_pkg::t_dp_status               o_status,
    output logic                               o_out_valid,
    output logic      [mm64_pkg::DATA_W-1:0]   o_hash_value
);

    logic [mm64_pkg::DATA_W-1:0] r_seed;
    logic [mm64_pkg::DATA_W-1:0] r_word;
    logic [mm64_pkg::LEN_W-1:0]  r_len;
    logic                        r_first;
    logic                        r_last;
    logic                        r_cnt_full;
    logic                        r_cnt_zero;
    logic [mm64_pkg::DATA_W-1:0] r_x;
    logic [mm64_pkg::DATA_W-1:0] r_h;
    logic [mm64_pkg::DATA_W-1:0] r_out;
    logic                        r_out_valid;
    logic [mm64_pkg::DATA_W-1:0] n_word;
    logic [mm64_pkg::DATA_W-1:0] n_x;
    logic [mm64_pkg::DATA_W-1:0] w_prod;
    logic [mm64_pkg::DATA_W-1:0] w_prod_mix;
    logic [mm64_pkg::DATA_W-1:0] w_h_mix;

    // keep only the valid bytes, counts above eight keep all
    always_comb begin
        for (int b = 0; b < mm64_pkg::NBYTES; b++) begin
            if (i_valid_bytes[mm64_pkg::CNT_W-1] ||
                (i_valid_bytes > mm64_pkg::CNT_W'(b))) begin
                n_word[b*8 +: 8] = i_data_word[b*8 +: 8];
            end else begin
                n_word[b*8 +: 8] = 8'h00;
            end
        end
    end

    // captured transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_word     <= n_word;
            r_len      <= i_total_length;
            r_first    <= i_first_item;
            r_last     <= i_last_item;
            r_cnt_full <= i_valid_bytes[mm64_pkg::CNT_W-1];
            r_cnt_zero <= (i_valid_bytes == '0);
        end
    end

    // seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end
    end

    mm64_mul u_mul (
        .i_clk     (i_clk),
        .i_phase   (i_cmd.mul),
        .i_operand (r_x),
        .o_product (w_prod)
    );

    assign w_prod_mix = w_prod ^ (w_prod >> mm64_pkg::MIX_SHIFT);
    assign w_h_mix    = r_h ^ (r_h >> mm64_pkg::MIX_SHIFT);

    // multiplier operand
    always_comb begin
        unique case (i_cmd.x_sel)
            mm64_pkg::X_LEN:  n_x = {{(mm64_pkg::DATA_W-mm64_pkg::LEN_W){1'b0}}, r_len};
            mm64_pkg::X_WORD: n_x = r_word;
            mm64_pkg::X_KMIX: n_x = w_prod_mix;
            mm64_pkg::X_HK:   n_x = r_h ^ w_prod;
            mm64_pkg::X_TAIL: n_x = r_h ^ r_word;
            mm64_pkg::X_AVAL: n_x = w_h_mix;
            default:          n_x = r_x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= '0;
        end else begin
            unique case (i_cmd.h_sel)
                mm64_pkg::H_SEED: r_h <= r_seed ^ w_prod;
                mm64_pkg::H_PROD: r_h <= w_prod;
                default:          r_h <= r_h;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= w_prod_mix;
        end
    end

    assign o_status.first    = r_first;
    assign o_status.last     = r_last;
    assign o_status.cnt_full = r_cnt_full;
    assign o_status.cnt_zero = r_cnt_zero;
    assign o_status.out_busy = r_out_valid & i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_hash_value      = r_out;

endmodule
`default_nettype wire

// ===== rtl/mm64_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm64_ctrl
// Sequencer of the hash core: steps each transaction through seeding,
// word mixing, tail folding and the final avalanche.
// ----------------------------------------------------------------------------
module mm64_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire mm64_pkg::t_dp_status  i_status,
    output mm64_pkg::t_dp_cmd          o_cmd,
    output logic                       o_in_stall
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_DONE,
        ST_WORD,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_LEN,
        OP_K1,
        OP_K2,
        OP_HW,
        OP_TAIL,
        OP_AVAL
    } t_op;

    t_state r_state;
    t_state n_state;
    t_op    r_op;
    t_op    n_op;
    logic   r_in_msg;
    logic   n_in_msg;
    logic   r_folded;
    logic   n_folded;
    logic   r_in_stall;

    // next state and datapath commands
    always_comb begin
        n_state        = r_state;
        n_op           = r_op;
        n_in_msg       = r_in_msg;
        n_folded       = r_folded;
        o_cmd.load_in  = 1'b0;
        o_cmd.x_sel    = mm64_pkg::X_HOLD;
        o_cmd.h_sel    = mm64_pkg::H_HOLD;
        o_cmd.mul      = mm64_pkg::MP_IDLE;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                n_folded = 1'b0;
                if (i_status.first) begin
                    n_in_msg    = 1'b1;
                    o_cmd.x_sel = mm64_pkg::X_LEN;
                    n_op        = OP_LEN;
                    n_state     = ST_MUL0;
                end else if (!r_in_msg) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_WORD;
                end
            end
            ST_MUL0: begin
                o_cmd.mul = mm64_pkg::MP_LO;
                n_state   = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul = mm64_pkg::MP_HL;
                n_state   = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul = mm64_pkg::MP_LH;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                // product is ready, route it by operation
                unique case (r_op)
                    OP_LEN: begin
                        o_cmd.h_sel = mm64_pkg::H_SEED;
                        n_state     = ST_WORD;
                    end
                    OP_K1: begin
                        o_cmd.x_sel = mm64_pkg::X_KMIX;
                        n_op        = OP_K2;
                        n_state     = ST_MUL0;
                    end
                    OP_K2: begin
                        o_cmd.x_sel = mm64_pkg::X_HK;
                        n_op        = OP_HW;
                        n_state     = ST_MUL0;
                    end
                    OP_HW, OP_TAIL: begin
                        o_cmd.h_sel = mm64_pkg::H_PROD;
                        n_folded    = 1'b1;
                        n_state     = ST_WORD;
                    end
                    default: begin
                        n_state = ST_OUT;
                    end
                endcase
            end
            ST_WORD: begin
                priority if (!r_folded && i_status.cnt_full) begin
                    o_cmd.x_sel = mm64_pkg::X_WORD;
                    n_op        = OP_K1;
                    n_state     = ST_MUL0;
                end else if (!r_folded && !i_status.cnt_zero) begin
                    o_cmd.x_sel = mm64_pkg::X_TAIL;
                    n_op        = OP_TAIL;
                    n_state     = ST_MUL0;
                end else if (i_status.last) begin
                    o_cmd.x_sel = mm64_pkg::X_AVAL;
                    n_op        = OP_AVAL;
                    n_state     = ST_MUL0;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                // wait until the output register is free
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_in_msg       = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_op       <= OP_LEN;
            r_in_msg   <= 1'b0;
            r_folded   <= 1'b0;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_op       <= n_op;
            r_in_msg   <= n_in_msg;
            r_folded   <= n_folded;
            r_in_stall <= (n_state != ST_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;

endmodule
`default_nettype wire

// ===== rtl/murmur64a_hash_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// murmur64a_hash_core
// Streaming MurmurHash64A of a message delivered as 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_stall) carries one 64-bit message
//   word per transaction, byte zero in bits 7:0, with its valid byte count
//   and first/last flags; the first word also carries the message length.
//   The output channel (o_out_valid / i_out_stall) carries one finished hash
//   per message, after the transaction flagged last.
//   The seed register is written through i_cfg_we / i_cfg_wdata; the user must
//   write it only while idle, as the core does not enforce this itself.
//   Every 64-bit multiply runs on one 32x32 multiplier in three partial
//   product steps, after which ST_DONE routes the product by operation.
//   A word outside a message is dropped and a word with no valid bytes folds
//   nothing in; a partial word takes the tail multiply, and a full word is
//   mixed and then folded. A first word adds the length multiply, a last word
//   the avalanche multiply and the load of the hash into the output register.
//   No new word is taken until the last is done; the multiplier sets the pace.
//   A new message may start while the previous hash still waits; the core
//   holds off loading the next hash until the waiting one is taken.
//   Reset is synchronous: it clears the seed, the sequencer and the output
//   valid flag, and ends any message in progress.
// ----------------------------------------------------------------------------
module murmur64a_hash_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mm64_pkg::DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [mm64_pkg::DATA_W-1:0]   i_data_word,
    input  wire logic [mm64_pkg::CNT_W-1:0]    i_valid_bytes,
    input  wire logic                          i_first_item,
    input  wire logic                          i_last_item,
    input  wire logic [mm64_pkg::LEN_W-1:0]    i_total_length,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic      [mm64_pkg::DATA_W-1:0]   o_hash_value
);

    mm64_pkg::t_dp_cmd    w_cmd;
    mm64_pkg::t_dp_status w_status;

    mm64_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    mm64_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_data_word    (i_data_word),
        .i_valid_bytes  (i_valid_bytes),
        .i_first_item   (i_first_item),
        .i_last_item    (i_last_item),
        .i_total_length (i_total_length),
        .i_out_stall    (i_out_stall),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_hash_value   (o_hash_value)
    );

    // busy right after a transaction is taken
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("input not stalled after accepted transaction");

    // a waiting hash is never overwritten
    a_no_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !w_status.out_busy
    ) else $error("hash loaded while previous hash waits");

    // a loaded hash is offered on the next cycle
    a_load_shows: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> o_out_valid
    ) else $error("loaded hash not offered");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming 64-bit murmur hash core. A table of
// hand-picked words runs first, then seeded phases of random messages, broken
// messages and noise, with random idle cycles on both channels. Each hash is
// checked against a bench model of the accumulator, or a pinned table hash.
// ----------------------------------------------------------------------------
module tb;

    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_PHASES       = 6;
    localparam int PER_PHASE      = 180;
    localparam int N_DIRECTED     = 23;

    // one input transaction, with an optional hand-typed expected hash
    typedef struct packed {
        logic [mm64_pkg::DATA_W-1:0] word;
        logic [mm64_pkg::CNT_W-1:0]  nbytes;
        logic                        first;
        logic                        last;
        logic [mm64_pkg::LEN_W-1:0]  len;
        logic                        pinned;
        logic [mm64_pkg::DATA_W-1:0] pin_hash;
    } t_vector;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [mm64_pkg::DATA_W-1:0] i_cfg_wdata;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [mm64_pkg::DATA_W-1:0] i_data_word;
    logic [mm64_pkg::CNT_W-1:0]  i_valid_bytes;
    logic                        i_first_item;
    logic                        i_last_item;
    logic [mm64_pkg::LEN_W-1:0]  i_total_length;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [mm64_pkg::DATA_W-1:0] o_hash_value;

    // bench side of the stimulus
    logic                        pin_valid;
    logic [mm64_pkg::DATA_W-1:0] pin_value;
    logic                        calm;

    // hash model state
    bit [mm64_pkg::DATA_W-1:0]   seed_now;
    bit [mm64_pkg::DATA_W-1:0]   run_hash;
    bit                          msg_open;
    bit [mm64_pkg::DATA_W-1:0]   pending_hashes [$];

    int                fail_count;
    int                hashes_checked;
    int                taken_items;
    int                ignored_items;
    int                idle_cycles;

    // directed words: extremes, odd counts, abandoned and mismatched messages
    t_vector directed_rows [N_DIRECTED] = '{
        // words outside a message are dropped
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b0, 1'b1, 31'h7FFF_FFFF, 1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b0, 1'b0, 31'h0,         1'b0, 64'h0},
        // empty message with a zero seed hashes to zero
        '{64'h0,                   4'd0,  1'b1, 1'b1, 31'h0,         1'b1, 64'h0},
        // zero-count words fold nothing in
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b1, 1'b0, 31'h0,         1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b0, 1'b1, 31'h0,         1'b1, 64'h0},
        // single full words, the oversized counts among them
        '{64'h0,                   4'd8,  1'b1, 1'b1, 31'd8,         1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b1, 1'b1, 31'd8,         1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1, 1'b1, 31'd8,         1'b0, 64'h0},
        '{64'h0123_4567_89AB_CDEF, 4'd9,  1'b1, 1'b1, 31'd8,         1'b0, 64'h0},
        // tails, bytes above the count must be masked
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd1,  1'b1, 1'b1, 31'd1,         1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd7,  1'b1, 1'b1, 31'd7,         1'b0, 64'h0},
        // largest length, partial word in the middle, oversized last count
        '{64'h8000_0000_0000_0001, 4'd8,  1'b1, 1'b0, 31'h7FFF_FFFF, 1'b0, 64'h0},
        '{64'hFEDC_BA98_7654_3210, 4'd3,  1'b0, 1'b0, 31'h0,         1'b0, 64'h0},
        '{64'h5555_5555_5555_5555, 4'd12, 1'b0, 1'b1, 31'h0,         1'b0, 64'h0},
        // a new first word abandons the open message
        '{64'hAAAA_AAAA_AAAA_AAAA, 4'd8,  1'b1, 1'b0, 31'd16,        1'b0, 64'h0},
        '{64'h0000_0000_0000_0001, 4'd8,  1'b1, 1'b0, 31'h4000_0000, 1'b0, 64'h0},
        '{64'h0000_0000_0000_0002, 4'd8,  1'b0, 1'b1, 31'h2AAA_AAAA, 1'b0, 64'h0},
        '{64'h00FF_00FF_00FF_00FF, 4'd4,  1'b1, 1'b1, 31'd4,         1'b0, 64'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b0, 1'b1, 31'h0,         1'b0, 64'h0},
        // several tails in a row
        '{64'h1122_3344_5566_7788, 4'd2,  1'b1, 1'b0, 31'd5,         1'b0, 64'h0},
        '{64'h99AA_BBCC_DDEE_FF00, 4'd5,  1'b0, 1'b0, 31'h5555_5555, 1'b0, 64'h0},
        '{64'h0F0F_0F0F_0F0F_0F0F, 4'd6,  1'b0, 1'b1, 31'h0,         1'b0, 64'h0},
        // empty message with the largest length
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b1, 1'b1, 31'h7FFF_FFFF, 1'b0, 64'h0}
    };

    murmur64a_hash_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_word    (i_data_word),
        .i_valid_bytes  (i_valid_bytes),
        .i_first_item   (i_first_item),
        .i_last_item    (i_last_item),
        .i_total_length (i_total_length),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_hash_value   (o_hash_value)
    );

    // 100 MHz clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // word mixing before the fold
    function automatic bit [mm64_pkg::DATA_W-1:0] scramble(
        input bit [mm64_pkg::DATA_W-1:0] k);
        k = k * mm64_pkg::MIX_MULT;
        k ^= k >> mm64_pkg::MIX_SHIFT;
        k = k * mm64_pkg::MIX_MULT;
        return k;
    endfunction

    // final avalanche of the accumulator
    function automatic bit [mm64_pkg::DATA_W-1:0] finish_hash(
        input bit [mm64_pkg::DATA_W-1:0] h);
        h ^= h >> mm64_pkg::MIX_SHIFT;
        h = h * mm64_pkg::MIX_MULT;
        h ^= h >> mm64_pkg::MIX_SHIFT;
        return h;
    endfunction

    // fold one accepted word into the running hash
    function automatic void absorb_word(input bit [mm64_pkg::DATA_W-1:0] word,
                                        input bit [mm64_pkg::CNT_W-1:0] nbytes,
                                        input bit first, input bit last,
                                        input bit [mm64_pkg::LEN_W-1:0] len,
                                        output bit live, output bit done,
                                        output bit [mm64_pkg::DATA_W-1:0] hash);
        bit [mm64_pkg::CNT_W-1:0]  cnt;
        bit [mm64_pkg::DATA_W-1:0] h;
        done = 1'b0;
        hash = '0;
        live = first || msg_open;
        if (!live)
            return;
        if (first) begin
            run_hash = seed_now ^ (64'(len) * mm64_pkg::MIX_MULT);
            msg_open = 1'b1;
        end
        cnt = (nbytes > mm64_pkg::NBYTES) ? mm64_pkg::CNT_W'(mm64_pkg::NBYTES) : nbytes;
        h = run_hash;
        if (cnt == mm64_pkg::NBYTES)
            h = (h ^ scramble(word)) * mm64_pkg::MIX_MULT;
        else if (cnt != 0)
            h = (h ^ (word & ((64'd1 << (8 * cnt)) - 64'd1))) * mm64_pkg::MIX_MULT;
        run_hash = h;
        if (last) begin
            hash = finish_hash(h);
            msg_open = 1'b0;
            done = 1'b1;
        end
    endfunction

    function automatic t_vector random_vector();
        t_vector v;
        v.word     = {$urandom, $urandom};
        v.nbytes   = mm64_pkg::CNT_W'($urandom_range(15));
        v.first    = 1'($urandom_range(1));
        v.last     = 1'($urandom_range(1));
        v.len      = mm64_pkg::LEN_W'($urandom);
        v.pinned   = 1'b0;
        v.pin_hash = '0;
        return v;
    endfunction

    // send one transaction, hold it until taken, idle at random unless calm
    task automatic send_word(input t_vector v);
        i_in_valid     <= 1'b1;
        i_data_word    <= v.word;
        i_valid_bytes  <= v.nbytes;
        i_first_item   <= v.first;
        i_last_item    <= v.last;
        i_total_length <= v.len;
        pin_valid      <= v.pinned;
        pin_value      <= v.pin_hash;
        do @(posedge i_clk); while (o_in_stall);
        if (!calm)
            while ($urandom_range(99) < 19) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
    endtask

    // a message cut into words; broken ones get a mutated word here and there
    task automatic send_message(input bit broken);
        int unsigned msg_len;
        int unsigned n_words;
        t_vector     v;
        msg_len = ($urandom_range(9) == 0) ? $urandom_range(200, 41) : $urandom_range(40);
        n_words = (msg_len == 0) ? 1 : (msg_len + 7) / 8;
        for (int unsigned i = 0; i < n_words; i++) begin
            v        = random_vector();
            v.first  = (i == 0);
            v.last   = (i == n_words - 1);
            v.nbytes = mm64_pkg::CNT_W'(mm64_pkg::NBYTES);
            if (v.last && (msg_len % 8 != 0 || msg_len == 0))
                v.nbytes = mm64_pkg::CNT_W'(msg_len % 8);
            if (v.first)
                v.len = mm64_pkg::LEN_W'(msg_len);
            if (broken && $urandom_range(2) == 0)
                case ($urandom_range(3))
                    0:       v.nbytes = mm64_pkg::CNT_W'($urandom_range(15));
                    1:       v.first  = ~v.first;
                    2:       v.last   = ~v.last;
                    default: v.len    = mm64_pkg::LEN_W'($urandom);
                endcase
            send_word(v);
        end
    endtask

    // stop sending until every hash is out and the core has settled
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_hashes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input bit [mm64_pkg::DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // output stall, none while calm
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 19);
    end

    // track seed writes, predict on input transactions, check output ones
    always @(posedge i_clk) begin : monitor
        bit                        took_in;
        bit                        took_out;
        bit                        live;
        bit                        done;
        bit [mm64_pkg::DATA_W-1:0] hash;
        bit [mm64_pkg::DATA_W-1:0] want;
        if (i_rst_n) begin
            if (i_cfg_we)
                seed_now = i_cfg_wdata;
            took_in  = i_in_valid && !o_in_stall;
            took_out = o_out_valid && !i_out_stall;
            if (took_in) begin
                absorb_word(i_data_word, i_valid_bytes, i_first_item, i_last_item,
                            i_total_length, live, done, hash);
                if (live)
                    taken_items++;
                else
                    ignored_items++;
                if (done)
                    pending_hashes = {pending_hashes, (pin_valid ? pin_value : hash)};
            end
            if (took_out) begin
                if (pending_hashes.size() == 0) begin
                    $error("hash_value: expected none, actual %h", o_hash_value);
                    fail_count++;
                end else begin
                    want = pending_hashes.pop_front();
                    hashes_checked++;
                    if (o_hash_value !== want) begin
                        $error("hash_value: expected %h, actual %h", want, o_hash_value);
                        fail_count++;
                    end
                end
            end
            // watchdog on cycles with no transaction on either side
            if (took_in || took_out)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        bit [mm64_pkg::DATA_W-1:0] seed_plan [N_PHASES];
        int                        phase_goal;
        int                        pick;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_data_word    = '0;
        i_valid_bytes  = '0;
        i_first_item   = 1'b0;
        i_last_item    = 1'b0;
        i_total_length = '0;
        i_out_stall    = 1'b0;
        pin_valid      = 1'b0;
        pin_value      = '0;
        calm           = 1'b0;
        seed_now       = '0;
        run_hash       = '0;
        msg_open       = 1'b0;
        fail_count     = 0;
        hashes_checked = 0;
        taken_items    = 0;
        ignored_items  = 0;
        idle_cycles    = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under the reset seed
        for (int row = 0; row < N_DIRECTED; row++)
            send_word(directed_rows[row]);
        drain_results();

        // random phases, each under its own seed; one phase without idling
        seed_plan[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        seed_plan[1] = {$urandom, $urandom};
        seed_plan[2] = 64'h0000_0000_0000_0001;
        seed_plan[3] = {$urandom, $urandom};
        seed_plan[4] = 64'h8000_0000_0000_0000;
        seed_plan[5] = 64'h0000_0000_0000_0000;
        for (int phase = 0; phase < N_PHASES; phase++) begin
            write_seed(seed_plan[phase]);
            calm <= (phase == 3);
            phase_goal = taken_items + PER_PHASE;
            while (taken_items < phase_goal) begin
                pick = $urandom_range(99);
                if (pick < 75)
                    send_message(1'b0);
                else if (pick < 90)
                    send_message(1'b1);
                else
                    repeat ($urandom_range(3, 1)) send_word(random_vector());
                if ($urandom_range(79) == 0)
                    drain_results();
            end
            drain_results();
            calm <= 1'b0;
        end

        if (pending_hashes.size() != 0) begin
            $error("hash_value: %0d expected hashes never came", pending_hashes.size());
            fail_count++;
        end
        $display("covered %0d message words and %0d dropped words under %0d seeds",
                 taken_items, ignored_items, N_PHASES + 1);
        $display("%0d hashes compared, %0d mismatches", hashes_checked, fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mm64_pkg.sv
rtl/mm64_mul.sv
rtl/mm64_dpath.sv
rtl/mm64_ctrl.sv
rtl/murmur64a_hash_core.sv
bench/tb.sv
